/* design/carv_pkg.sv */
`timescale 1ns / 1ps

package carv_pkg;

   localparam int NUM_COMBS = 6;
   localparam int NUM_APS   = 6;
   localparam int NUM_LINES = NUM_COMBS + NUM_APS;
   localparam int NUM_REGS  = 8;

   localparam int COMB_DEPTH = 20480;
   localparam int AP_DEPTH   = 2048;
   localparam int COMB_AW    = $clog2(COMB_DEPTH);
   localparam int AP_AW      = $clog2(AP_DEPTH);
   localparam int POS_W      = 13;

   typedef logic [POS_W-1:0] pos_type;

   // prime lengths of all lines at 44.1 kHz, combs first
   localparam pos_type LINE_LEN [NUM_LINES] = '{
      13'd2467, 13'd2753, 13'd3217, 13'd3533, 13'd3877, 13'd4127,
      13'd599,  13'd197,  13'd67,   13'd101,  13'd97,   13'd73
   };

   localparam logic [COMB_AW-1:0] COMB_OFF [NUM_COMBS] = '{
      15'd0, 15'd2467, 15'd5220, 15'd8437, 15'd11970, 15'd15847
   };

   localparam logic [AP_AW-1:0] AP_OFF [NUM_APS] = '{
      11'd0, 11'd599, 11'd796, 11'd863, 11'd964, 11'd1061
   };

   localparam logic [15:0] LP_POLE  = 16'd45875;
   localparam logic [15:0] LP_INPUT = 16'd19661;
   localparam logic [15:0] UNITY    = 16'd32768;

   localparam int REG_WET_MIX = 7;
   localparam int REG_AP_GAIN = 6;

   localparam logic [14:0] REG_RESET [NUM_REGS] = '{
      15'd22282, 15'd21290, 15'd19793, 15'd18843,
      15'd17869, 15'd17171, 15'd22938, 15'd9830
   };

   typedef struct packed {
      logic [NUM_COMBS-1:0][14:0] comb_gain;
      logic [14:0]                ap_gain;
      logic [14:0]                wet_mix;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COMB_RD,
      ST_COMB_WR,
      ST_AP_RD,
      ST_AP_WR,
      ST_AP_MUL,
      ST_AP_OUT,
      ST_LP_A,
      ST_LP_B,
      ST_LP_C,
      ST_MIX_A,
      ST_MIX_B,
      ST_MIX_C,
      ST_DONE
   } state_type;

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      logic signed [15:0] r;
      if (v > 36'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -36'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] mulq(input logic signed [32:0] p);
      logic signed [35:0] s;
      s = (36'(p) + 36'sd16384) >>> 15;
      return sat16(s);
   endfunction

endpackage

/* design/carv_front.sv */
`timescale 1ns / 1ps

module carv_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_in_sample,
   output logic               q_valid,
   input  logic               q_ready,
   output logic signed [15:0] q_sample
);

   logic signed [15:0] data_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   assign req_ready = (count_ff != 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_sample  = data_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= req_in_sample;
      end
   end

endmodule

/* design/carv_engine.sv */
`timescale 1ns / 1ps

module carv_engine (
   input  logic               clock,
   input  logic               reset,
   input  carv_pkg::cfg_type  cfg,
   input  logic               q_valid,
   output logic               q_ready,
   input  logic signed [15:0] q_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_out_left,
   output logic signed [15:0] rsp_out_right,
   output logic signed [15:0] rsp_out_mono
);

   carv_pkg::state_type state_ff, state_in;

   logic signed [15:0] comb_mem [carv_pkg::COMB_DEPTH];
   logic signed [15:0] ap_mem   [carv_pkg::AP_DEPTH];

   logic signed [15:0] comb_q_ff, ap_q_ff;
   logic               comb_we, ap_we;
   logic signed [15:0] wr_data;
   logic [carv_pkg::COMB_AW-1:0] comb_addr;
   logic [carv_pkg::AP_AW-1:0]   ap_addr;

   carv_pkg::pos_type  pos_ff [carv_pkg::NUM_LINES];
   carv_pkg::pos_type  pos_in [carv_pkg::NUM_LINES];
   logic [carv_pkg::NUM_LINES-1:0] wrapped_ff, wrapped_in;
   logic signed [15:0] comb_last_ff [carv_pkg::NUM_COMBS];
   logic signed [15:0] comb_last_in [carv_pkg::NUM_COMBS];
   logic signed [15:0] ap_last_ff [carv_pkg::NUM_APS];
   logic signed [15:0] ap_last_in [carv_pkg::NUM_APS];
   logic signed [15:0] lp_ff, lp_in;

   logic [2:0]         idx_ff, idx_in;
   logic               side_ff, side_in;
   logic signed [15:0] x_ff, x_in;
   logic signed [15:0] ap_in_ff, ap_in_in;
   logic signed [15:0] s1_ff, s1_in;
   logic signed [15:0] t_ff, t_in;
   logic signed [15:0] prev_ff, prev_in;
   logic signed [15:0] wl_ff, wl_in;
   logic signed [15:0] wr_ff, wr_in;
   logic signed [15:0] l_ff, l_in;
   logic signed [35:0] acc_ff, acc_in;
   logic signed [32:0] prod_ff, prod_in;
   logic signed [15:0] mul_a;
   logic [15:0]        mul_b;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] out_l_ff, out_l_in;
   logic signed [15:0] out_r_ff, out_r_in;
   logic signed [15:0] out_m_ff, out_m_in;

   logic [3:0]         line;
   logic signed [15:0] line_q;
   logic signed [15:0] rnd_v;
   logic signed [15:0] res_v;
   logic signed [16:0] msum;
   logic [15:0]        dry;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = out_l_ff;
   assign rsp_out_right = out_r_ff;
   assign rsp_out_mono  = out_m_ff;

   assign dry       = carv_pkg::UNITY - {1'b0, cfg.wet_mix};
   assign prod_in   = 33'(mul_a) * 33'($signed({1'b0, mul_b}));
   assign comb_addr = carv_pkg::COMB_OFF[idx_ff] + {2'b00, pos_ff[{1'b0, idx_ff}]};
   assign ap_addr   = carv_pkg::AP_OFF[idx_ff]
                      + pos_ff[4'(idx_ff) + 4'd6][carv_pkg::AP_AW-1:0];

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      wrapped_in   = wrapped_ff;
      comb_last_in = comb_last_ff;
      ap_last_in   = ap_last_ff;
      lp_in        = lp_ff;
      idx_in       = idx_ff;
      side_in      = side_ff;
      x_in         = x_ff;
      ap_in_in     = ap_in_ff;
      s1_in        = s1_ff;
      t_in         = t_ff;
      prev_in      = prev_ff;
      wl_in        = wl_ff;
      wr_in        = wr_ff;
      l_in         = l_ff;
      acc_in       = acc_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      out_m_in     = out_m_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_ready      = 1'b0;
      comb_we      = 1'b0;
      ap_we        = 1'b0;
      wr_data      = '0;
      mul_a        = '0;
      mul_b        = '0;
      res_v        = '0;
      msum         = '0;

      if (state_ff == carv_pkg::ST_COMB_RD || state_ff == carv_pkg::ST_COMB_WR) begin
         line   = {1'b0, idx_ff};
         line_q = wrapped_ff[line] ? comb_q_ff : 16'sd0;
      end else begin
         line   = 4'(idx_ff) + 4'd6;
         line_q = wrapped_ff[line] ? ap_q_ff : 16'sd0;
      end
      rnd_v = carv_pkg::mulq(prod_ff);

      unique case (state_ff)
         carv_pkg::ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               x_in     = q_sample;
               ap_in_in = '0;
               idx_in   = '0;
               state_in = carv_pkg::ST_COMB_RD;
            end
         end
         carv_pkg::ST_COMB_RD: begin
            mul_a    = comb_last_ff[idx_ff];
            mul_b    = {1'b0, cfg.comb_gain[idx_ff]};
            state_in = carv_pkg::ST_COMB_WR;
         end
         carv_pkg::ST_COMB_WR: begin
            comb_we              = 1'b1;
            wr_data              = carv_pkg::sat16(36'(x_ff) + 36'(rnd_v));
            comb_last_in[idx_ff] = line_q;
            ap_in_in             = carv_pkg::sat16(36'(ap_in_ff) + 36'(line_q));
            if (pos_ff[line] == carv_pkg::LINE_LEN[line] - 13'd1) begin
               pos_in[line]     = '0;
               wrapped_in[line] = 1'b1;
            end else begin
               pos_in[line] = pos_ff[line] + 13'd1;
            end
            if (idx_ff == 3'(carv_pkg::NUM_COMBS - 1)) begin
               idx_in   = '0;
               state_in = carv_pkg::ST_AP_RD;
            end else begin
               idx_in   = idx_ff + 3'd1;
               state_in = carv_pkg::ST_COMB_RD;
            end
         end
         carv_pkg::ST_AP_RD: begin
            mul_a    = ap_last_ff[idx_ff];
            mul_b    = {1'b0, cfg.ap_gain};
            state_in = carv_pkg::ST_AP_WR;
         end
         carv_pkg::ST_AP_WR: begin
            ap_we              = 1'b1;
            wr_data            = carv_pkg::sat16(36'(rnd_v) + 36'(ap_in_ff));
            t_in               = wr_data;
            prev_in            = ap_last_ff[idx_ff];
            ap_last_in[idx_ff] = line_q;
            if (pos_ff[line] == carv_pkg::LINE_LEN[line] - 13'd1) begin
               pos_in[line]     = '0;
               wrapped_in[line] = 1'b1;
            end else begin
               pos_in[line] = pos_ff[line] + 13'd1;
            end
            state_in = carv_pkg::ST_AP_MUL;
         end
         carv_pkg::ST_AP_MUL: begin
            mul_a    = t_ff;
            mul_b    = {1'b0, cfg.ap_gain};
            state_in = carv_pkg::ST_AP_OUT;
         end
         carv_pkg::ST_AP_OUT: begin
            res_v  = carv_pkg::sat16(36'(prev_ff) - 36'(rnd_v));
            idx_in = idx_ff + 3'd1;
            priority if (idx_ff == 3'd2) begin
               ap_in_in = res_v;
               state_in = carv_pkg::ST_LP_A;
            end else if (idx_ff == 3'd3) begin
               s1_in    = res_v;
               ap_in_in = res_v;
               state_in = carv_pkg::ST_AP_RD;
            end else if (idx_ff == 3'd4) begin
               wl_in    = res_v;
               ap_in_in = s1_ff;
               state_in = carv_pkg::ST_AP_RD;
            end else if (idx_ff == 3'd5) begin
               wr_in    = res_v;
               side_in  = 1'b0;
               state_in = carv_pkg::ST_MIX_A;
            end else begin
               ap_in_in = res_v;
               state_in = carv_pkg::ST_AP_RD;
            end
         end
         carv_pkg::ST_LP_A: begin
            mul_a    = lp_ff;
            mul_b    = carv_pkg::LP_POLE;
            state_in = carv_pkg::ST_LP_B;
         end
         carv_pkg::ST_LP_B: begin
            mul_a    = ap_in_ff;
            mul_b    = carv_pkg::LP_INPUT;
            acc_in   = 36'(prod_ff);
            state_in = carv_pkg::ST_LP_C;
         end
         carv_pkg::ST_LP_C: begin
            lp_in    = carv_pkg::sat16((acc_ff + 36'(prod_ff) + 36'sd32768) >>> 16);
            ap_in_in = lp_in;
            idx_in   = 3'd3;
            state_in = carv_pkg::ST_AP_RD;
         end
         carv_pkg::ST_MIX_A: begin
            mul_a    = side_ff ? wr_ff : wl_ff;
            mul_b    = {1'b0, cfg.wet_mix};
            state_in = carv_pkg::ST_MIX_B;
         end
         carv_pkg::ST_MIX_B: begin
            mul_a    = x_ff;
            mul_b    = dry;
            acc_in   = 36'(prod_ff);
            state_in = carv_pkg::ST_MIX_C;
         end
         carv_pkg::ST_MIX_C: begin
            res_v = carv_pkg::sat16((acc_ff + 36'(prod_ff) + 36'sd16384) >>> 15);
            if (side_ff) begin
               t_in     = res_v;
               state_in = carv_pkg::ST_DONE;
            end else begin
               l_in     = res_v;
               side_in  = 1'b1;
               state_in = carv_pkg::ST_MIX_A;
            end
         end
         carv_pkg::ST_DONE: begin
            msum = 17'(l_ff) + 17'(t_ff) + 17'sd1;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_l_in     = l_ff;
               out_r_in     = t_ff;
               out_m_in     = msum[16:1];
               state_in     = carv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = carv_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= carv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wrapped_ff   <= '0;
         lp_ff        <= '0;
         for (int i = 0; i < carv_pkg::NUM_LINES; i++) begin
            pos_ff[i] <= '0;
         end
         for (int i = 0; i < carv_pkg::NUM_COMBS; i++) begin
            comb_last_ff[i] <= '0;
            ap_last_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wrapped_ff   <= wrapped_in;
         lp_ff        <= lp_in;
         pos_ff       <= pos_in;
         comb_last_ff <= comb_last_in;
         ap_last_ff   <= ap_last_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      side_ff  <= side_in;
      x_ff     <= x_in;
      ap_in_ff <= ap_in_in;
      s1_ff    <= s1_in;
      t_ff     <= t_in;
      prev_ff  <= prev_in;
      wl_ff    <= wl_in;
      wr_ff    <= wr_in;
      l_ff     <= l_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
      out_m_ff <= out_m_in;
   end

   always_ff @(posedge clock) begin
      comb_q_ff <= comb_mem[comb_addr];
      if (comb_we) begin
         comb_mem[comb_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      ap_q_ff <= ap_mem[ap_addr];
      if (ap_we) begin
         ap_mem[ap_addr] <= wr_data;
      end
   end

endmodule

/* design/comb_allpass_reverb_core.sv */
`timescale 1ns / 1ps
// Mono-in, stereo-out reverberator: six feedback combs, an allpass chain,
// a one-pole lowpass and a left/right allpass pair, each side mixed with dry.
// Input channel: req_valid/req_ready carry one signed Q1.15 sample per
// transaction. Result channel: rsp_valid/rsp_ready carry left, right and mono.
// A two-entry input queue takes samples while the engine works; the engine
// takes one sample at a time and shares one 16x16 multiplier and one
// read/write port per delay memory across all steps.
// Each sample runs the step sequence: comb read and write for each comb,
// allpass read, write, multiply and output for each allpass, the lowpass
// steps, the mix steps for each side, and the hand-off of the result.
// The result sits in an output register; while the receiver stalls, the
// engine holds a finished result and the input queue still fills.
// Reset is synchronous and active high: it empties the queue, clears the
// feedback state and marks every delay line empty, so lines read as zero
// until written once; no clearing pass is needed. Registers return to
// their default gains. Write registers over the APB port only when idle.

module comb_allpass_reverb_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_in_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_out_left,
   output logic signed [15:0] rsp_out_right,
   output logic signed [15:0] rsp_out_mono,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [14:0] reg_ff [carv_pkg::NUM_REGS];
   logic [2:0]  reg_idx;
   logic        reg_we;
   carv_pkg::cfg_type cfg;

   logic               q_valid, q_ready;
   logic signed [15:0] q_sample;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign reg_we  = psel && penable && pwrite && pready;
   assign prdata  = {17'd0, reg_ff[reg_idx]};

   always_comb begin
      for (int i = 0; i < carv_pkg::NUM_COMBS; i++) begin
         cfg.comb_gain[i] = reg_ff[i];
      end
      cfg.ap_gain = reg_ff[carv_pkg::REG_AP_GAIN];
      cfg.wet_mix = reg_ff[carv_pkg::REG_WET_MIX];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < carv_pkg::NUM_REGS; i++) begin
            reg_ff[i] <= carv_pkg::REG_RESET[i];
         end
      end else if (reg_we) begin
         reg_ff[reg_idx] <= pwdata[14:0];
      end
   end

   carv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_sample (req_in_sample),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_sample      (q_sample)
   );

   carv_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_sample      (q_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right),
      .rsp_out_mono  (rsp_out_mono)
   );

`ifndef SYNTHESIS
   a_mono_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (17'(rsp_out_mono) ==
                     ((17'(rsp_out_left) + 17'(rsp_out_right) + 17'sd1) >>> 1)))
      else $error("mono output is not the mean of left and right");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("reset left a result or a full queue");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> !q_ready)
      else $error("engine took a second transaction while busy");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int  MAX_LEN     = 4127;
   localparam int  IDLE_PCT    = 28;
   localparam int  TAIL_CYCLES = 100;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic signed [15:0] mono;
   } mix_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_in_sample = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_out_left;
   logic signed [15:0] rsp_out_right;
   logic signed [15:0] rsp_out_mono;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   comb_allpass_reverb_core dut (.*);

   // reverb model state
   logic signed [15:0] line_mem [carv_pkg::NUM_LINES][MAX_LEN];
   int                 line_pos [carv_pkg::NUM_LINES];
   longint             comb_last [carv_pkg::NUM_COMBS];
   longint             ap_last [carv_pkg::NUM_APS];
   longint             lp_state;
   longint             gain_reg [carv_pkg::NUM_REGS];

   mix_type expected_mix_q [$];
   int      errors = 0;
   int      n_sent = 0;
   int      n_checked = 0;
   int      n_cfg = 0;
   longint  cycles = 0;
   bit      quiet_sides = 1'b0;
   int      hold_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint scale_q15(longint a, longint g);
      return sat16((a * g + 16384) >>> 15);
   endfunction

   function automatic longint line_step(int k, longint v);
      longint o;
      o = line_mem[k][line_pos[k]];
      line_mem[k][line_pos[k]] = v[15:0];
      line_pos[k] = (line_pos[k] + 1 >= int'(carv_pkg::LINE_LEN[k])) ? 0 : line_pos[k] + 1;
      return o;
   endfunction

   function automatic longint allpass_step(int k, longint x);
      longint prev, t;
      prev = ap_last[k];
      t = sat16(scale_q15(prev, gain_reg[carv_pkg::REG_AP_GAIN]) + x);
      ap_last[k] = line_step(k + carv_pkg::NUM_COMBS, t);
      return sat16(prev - scale_q15(t, gain_reg[carv_pkg::REG_AP_GAIN]));
   endfunction

   function automatic void reverb_clear();
      for (int k = 0; k < carv_pkg::NUM_LINES; k++) begin
         line_pos[k] = 0;
         for (int j = 0; j < MAX_LEN; j++) line_mem[k][j] = '0;
      end
      for (int i = 0; i < carv_pkg::NUM_COMBS; i++) comb_last[i] = 0;
      for (int i = 0; i < carv_pkg::NUM_APS; i++) ap_last[i] = 0;
      for (int i = 0; i < carv_pkg::NUM_REGS; i++) gain_reg[i] = carv_pkg::REG_RESET[i];
      lp_state = 0;
   endfunction

   function automatic mix_type reverb_predict(logic signed [15:0] smp);
      longint x, sum, s, s1, wl, wr, wet, dry, l, r;
      mix_type m;
      x = smp;
      sum = 0;
      for (int i = 0; i < carv_pkg::NUM_COMBS; i++) begin
         comb_last[i] = line_step(i, sat16(x + scale_q15(comb_last[i], gain_reg[i])));
         sum = sat16(sum + comb_last[i]);
      end
      s = sum;
      for (int i = 0; i < 3; i++) s = allpass_step(i, s);
      lp_state = sat16((longint'(carv_pkg::LP_POLE) * lp_state +
                        longint'(carv_pkg::LP_INPUT) * s + 32768) >>> 16);
      s1 = allpass_step(3, lp_state);
      wl = allpass_step(4, s1);
      wr = allpass_step(5, s1);
      wet = gain_reg[carv_pkg::REG_WET_MIX];
      dry = 32768 - wet;
      l = sat16((wet * wl + dry * x + 16384) >>> 15);
      r = sat16((wet * wr + dry * x + 16384) >>> 15);
      m.left = l[15:0];
      m.right = r[15:0];
      m.mono = 16'((l + r + 1) >>> 1);
      return m;
   endfunction

   task automatic send_sample(logic signed [15:0] smp);
      @(negedge clock);
      if (!quiet_sides && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_sample <= smp;
      do @(posedge clock); while (!req_ready);
      expected_mix_q.push_back(reverb_predict(smp));
      n_sent++;
   endtask

   task automatic pause_input();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      pause_input();
      while (expected_mix_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 5'(idx * 4);
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      gain_reg[idx] = data[14:0];
      n_cfg++;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic load_gains(logic [14:0] comb_g, logic [14:0] ap_g, logic [14:0] wet);
      wait_drained();
      for (int i = 0; i < carv_pkg::NUM_COMBS; i++) csr_write(i, {17'h0, comb_g});
      csr_write(carv_pkg::REG_AP_GAIN, {17'h0, ap_g});
      csr_write(carv_pkg::REG_WET_MIX, {17'h0, wet});
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2, 3: return 16'($signed($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver: random stalls, or a counted hold-off
   initial begin
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= quiet_sides || ($urandom_range(99) >= IDLE_PCT);
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      mix_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_mix_q.size() == 0) begin
            $display("%0t: unexpected transaction L=%0d R=%0d M=%0d", $time,
                     rsp_out_left, rsp_out_right, rsp_out_mono);
            errors++;
         end else begin
            e = expected_mix_q.pop_front();
            n_checked++;
            if (rsp_out_left !== e.left) begin
               $display("%0t: left exp %0d got %0d", $time, e.left, rsp_out_left);
               errors++;
            end
            if (rsp_out_right !== e.right) begin
               $display("%0t: right exp %0d got %0d", $time, e.right, rsp_out_right);
               errors++;
            end
            if (rsp_out_mono !== e.mono) begin
               $display("%0t: mono exp %0d got %0d", $time, e.mono, rsp_out_mono);
               errors++;
            end
         end
      end
   end

   task automatic test_extremes();
      logic signed [15:0] pts [8] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                                     16'sh0001, 16'sh5555, 16'shaaaa, 16'sh4000};
      foreach (pts[i]) send_sample(pts[i]);
      for (int i = 0; i < 6; i++) send_sample(16'sh0000);
   endtask

   task automatic test_dry_only();
      load_gains(15'd0, 15'd0, 15'd0);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sh1234);
   endtask

   task automatic test_saturation();
      load_gains(15'h7fff, 15'h7fff, 15'h7fff);
      for (int i = 0; i < 6; i++) send_sample((i % 2) ? 16'sh8000 : 16'sh7fff);
      // upper data bits are dropped by the register
      wait_drained();
      csr_write(carv_pkg::REG_WET_MIX, 32'hffff_4000);
      csr_write(carv_pkg::REG_AP_GAIN, 32'h8000_0000 | 32'($urandom_range(32767)));
      send_sample(16'sh7fff);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) begin
            wait_drained();
            for (int r = 0; r < carv_pkg::NUM_REGS; r++) csr_write(r, $urandom);
         end
         send_sample(pick_sample());
      end
   endtask

   task automatic test_streaming();
      wait_drained();
      quiet_sides = 1'b1;
      for (int i = 0; i < 80; i++) send_sample(16'($urandom));
      quiet_sides = 1'b0;
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_cycles = 500;
      for (int i = 0; i < 20; i++) send_sample(pick_sample());
   endtask

   task automatic test_defaults();
      load_gains(15'd22282, 15'd22938, 15'd9830);
      for (int i = 0; i < carv_pkg::NUM_COMBS; i++) begin
         csr_write(i, {17'h0, carv_pkg::REG_RESET[i]});
      end
      for (int i = 0; i < 60; i++) send_sample(pick_sample());
   endtask

   initial begin
      reverb_clear();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_dry_only();
      test_saturation();
      test_defaults();
      test_random(600);
      test_streaming();
      test_backpressure();
      test_random(120);
      pause_input();
      while (expected_mix_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d samples, %0d results checked, %0d register writes,",
               n_sent, n_checked, n_cfg);
      $display("gain extremes, dry-only mix, saturation, stalls and a long hold-off");
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
